/* rtl/core/pac_pkg.sv */
// Shared constants, codes and types of the polygon area and centroid block.
package pac_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int COORD_BITS   = 16;

   localparam int IN_W    = 16;
   localparam int CENT_W  = 16;
   localparam int AREA_W  = 43;
   localparam int MOM_W   = 60;

   localparam int PROD_W  = 2 * COORD_BITS;
   localparam int CROSS_W = PROD_W + 1;
   localparam int SUM_W   = COORD_BITS + 1;
   localparam int TERM_W  = SUM_W + CROSS_W;

   localparam int VCOUNT_W = $clog2(MAX_VERTICES + 2);

   localparam int DEN_W  = AREA_W + 1;
   localparam int DVS_W  = DEN_W + 1;
   localparam int NUM_W  = MOM_W + 1;
   localparam int DCNT_W = $clog2(NUM_W + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_AREA = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_CROSS,
      F_MOMX,
      F_MOMY,
      F_ACC,
      F_CLOSE,
      F_EMIT
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ABS,
      B_DEN,
      B_NUM,
      B_DIVX,
      B_DIVY,
      B_OUT
   } back_state_type;

   typedef struct packed {
      logic signed [AREA_W-1:0] contour_area;
      logic                     clockwise;
      logic                     done;
      logic signed [AREA_W-1:0] poly_area;
      logic signed [MOM_W-1:0]  moment_x;
      logic signed [MOM_W-1:0]  moment_y;
      logic                     overflow;
   } pac_entry_type;

endpackage

/* rtl/core/pac_if.sv */
// Request and response channel interfaces of the polygon area and centroid block.
interface pac_req_if import pac_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] vertex_x;
   logic signed [IN_W-1:0] vertex_y;
   logic                   contour_last;
   logic                   polygon_last;
   logic                   hole_flag;
   logic                   open_flag;

   modport source (output valid, output vertex_x, output vertex_y, output contour_last,
                   output polygon_last, output hole_flag, output open_flag, input ready);
   modport sink (input valid, input vertex_x, input vertex_y, input contour_last,
                 input polygon_last, input hole_flag, input open_flag, output ready);
endinterface

interface pac_rsp_if import pac_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [AREA_W-1:0] contour_double_area;
   logic                     contour_clockwise;
   logic                     polygon_done;
   logic signed [AREA_W-1:0] polygon_double_area;
   logic signed [CENT_W-1:0] centroid_x;
   logic signed [CENT_W-1:0] centroid_y;
   logic [1:0]               status;

   modport source (output valid, output contour_double_area, output contour_clockwise,
                   output polygon_done, output polygon_double_area, output centroid_x,
                   output centroid_y, output status, input ready);
   modport sink (input valid, input contour_double_area, input contour_clockwise,
                 input polygon_done, input polygon_double_area, input centroid_x,
                 input centroid_y, input status, output ready);
endinterface

/* rtl/core/pac_front.sv */
// Front end: accepts vertices and accumulates the shoelace and moment sums per contour.
module pac_front import pac_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   pac_req_if.sink       req_chan,
   output logic          push_valid,
   input  logic          push_ready,
   output pac_entry_type push_data
);

   front_state_type state_ff, state_in;

   logic signed [COORD_BITS-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                         started_ff, started_in;
   logic                         cont_end_ff, cont_end_in, poly_end_ff, poly_end_in;
   logic                         hole_ff, hole_in, open_ff, open_in;
   logic                         closing_ff, closing_in;
   logic signed [COORD_BITS-1:0] ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [PROD_W-1:0]     p1_ff, p1_in, p2_ff, p2_in;
   logic signed [SUM_W-1:0]      sx_ff, sx_in, sy_ff, sy_in;
   logic signed [CROSS_W-1:0]    c_ff, c_in;
   logic signed [TERM_W-1:0]     prod_ff, prod_in;
   logic signed [AREA_W-1:0]     cross_sum_ff, cross_sum_in;
   logic signed [MOM_W-1:0]      cmom_x_ff, cmom_x_in, cmom_y_ff, cmom_y_in;
   logic signed [AREA_W-1:0]     parea_ff, parea_in;
   logic signed [MOM_W-1:0]      pmom_x_ff, pmom_x_in, pmom_y_ff, pmom_y_in;
   logic [VCOUNT_W-1:0]          vcount_ff, vcount_in;

   logic signed [COORD_BITS-1:0] in_x, in_y;
   logic                         accept, in_cont_end;
   logic signed [SUM_W-1:0]      mul_a;
   logic signed [TERM_W-1:0]     mul_p;
   logic                         d_neg, d_zero, flip;

   assign in_x        = req_chan.vertex_x[COORD_BITS-1:0];
   assign in_y        = req_chan.vertex_y[COORD_BITS-1:0];
   assign accept      = req_chan.valid && req_chan.ready;
   assign in_cont_end = req_chan.contour_last || req_chan.polygon_last;

   assign mul_a  = (state_ff == F_MOMY) ? sy_ff : sx_ff;
   assign mul_p  = TERM_W'(mul_a) * TERM_W'(c_ff);
   assign d_neg  = cross_sum_ff[AREA_W-1];
   assign d_zero = (cross_sum_ff == '0);
   assign flip   = d_neg ^ hole_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept && (started_ff || in_cont_end)) begin
               state_in = F_MUL;
            end
         end
         F_MUL:   state_in = F_CROSS;
         F_CROSS: state_in = F_MOMX;
         F_MOMX:  state_in = F_MOMY;
         F_MOMY:  state_in = F_ACC;
         F_ACC: begin
            if (cont_end_ff && !closing_ff) begin
               state_in = F_MUL;
            end else if (cont_end_ff) begin
               state_in = F_CLOSE;
            end else begin
               state_in = F_IDLE;
            end
         end
         F_CLOSE: state_in = F_EMIT;
         F_EMIT: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == F_IDLE);
      push_valid     = (state_ff == F_EMIT);
   end

   assign push_data.contour_area = cross_sum_ff;
   assign push_data.clockwise    = d_neg;
   assign push_data.done         = poly_end_ff;
   assign push_data.poly_area    = parea_ff;
   assign push_data.moment_x     = pmom_x_ff;
   assign push_data.moment_y     = pmom_y_ff;
   assign push_data.overflow     = (vcount_ff > VCOUNT_W'(MAX_VERTICES));

   always_comb begin
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      started_in   = started_ff;
      cont_end_in  = cont_end_ff;
      poly_end_in  = poly_end_ff;
      hole_in      = hole_ff;
      open_in      = open_ff;
      closing_in   = closing_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      c_in         = c_ff;
      prod_in      = prod_ff;
      cross_sum_in = cross_sum_ff;
      cmom_x_in    = cmom_x_ff;
      cmom_y_in    = cmom_y_ff;
      parea_in     = parea_ff;
      pmom_x_in    = pmom_x_ff;
      pmom_y_in    = pmom_y_ff;
      vcount_in    = vcount_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               cont_end_in = in_cont_end;
               poly_end_in = req_chan.polygon_last;
               hole_in     = req_chan.hole_flag;
               open_in     = req_chan.open_flag;
               prev_x_in   = in_x;
               prev_y_in   = in_y;
               bx_in       = in_x;
               by_in       = in_y;
               if (vcount_ff <= VCOUNT_W'(MAX_VERTICES)) begin
                  vcount_in = vcount_ff + VCOUNT_W'(1);
               end
               if (started_ff) begin
                  ax_in      = prev_x_ff;
                  ay_in      = prev_y_ff;
                  closing_in = 1'b0;
               end else begin
                  first_x_in = in_x;
                  first_y_in = in_y;
                  started_in = 1'b1;
                  ax_in      = in_x;
                  ay_in      = in_y;
                  closing_in = 1'b1;
               end
            end
         end
         F_MUL: begin
            p1_in = PROD_W'(ax_ff) * PROD_W'(by_ff);
            p2_in = PROD_W'(bx_ff) * PROD_W'(ay_ff);
            sx_in = SUM_W'(ax_ff) + SUM_W'(bx_ff);
            sy_in = SUM_W'(ay_ff) + SUM_W'(by_ff);
         end
         F_CROSS: begin
            c_in = CROSS_W'(p1_ff) - CROSS_W'(p2_ff);
         end
         F_MOMX: begin
            cross_sum_in = cross_sum_ff + AREA_W'(c_ff);
            prod_in      = mul_p;
         end
         F_MOMY: begin
            cmom_x_in = cmom_x_ff + MOM_W'(prod_ff);
            prod_in   = mul_p;
         end
         F_ACC: begin
            cmom_y_in = cmom_y_ff + MOM_W'(prod_ff);
            if (cont_end_ff && !closing_ff) begin
               ax_in      = prev_x_ff;
               ay_in      = prev_y_ff;
               bx_in      = first_x_ff;
               by_in      = first_y_ff;
               closing_in = 1'b1;
            end
         end
         F_CLOSE: begin
            if (!open_ff) begin
               parea_in = flip ? (parea_ff - cross_sum_ff) : (parea_ff + cross_sum_ff);
               if (!d_zero) begin
                  pmom_x_in = flip ? (pmom_x_ff - cmom_x_ff) : (pmom_x_ff + cmom_x_ff);
                  pmom_y_in = flip ? (pmom_y_ff - cmom_y_ff) : (pmom_y_ff + cmom_y_ff);
               end
            end
         end
         F_EMIT: begin
            if (push_ready) begin
               started_in   = 1'b0;
               cross_sum_in = '0;
               cmom_x_in    = '0;
               cmom_y_in    = '0;
               if (poly_end_ff) begin
                  parea_in  = '0;
                  pmom_x_in = '0;
                  pmom_y_in = '0;
                  vcount_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         started_ff   <= 1'b0;
         cross_sum_ff <= '0;
         cmom_x_ff    <= '0;
         cmom_y_ff    <= '0;
         parea_ff     <= '0;
         pmom_x_ff    <= '0;
         pmom_y_ff    <= '0;
         vcount_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         started_ff   <= started_in;
         cross_sum_ff <= cross_sum_in;
         cmom_x_ff    <= cmom_x_in;
         cmom_y_ff    <= cmom_y_in;
         parea_ff     <= parea_in;
         pmom_x_ff    <= pmom_x_in;
         pmom_y_ff    <= pmom_y_in;
         vcount_ff    <= vcount_in;
      end
   end

   always_ff @(posedge clock) begin
      cont_end_ff <= cont_end_in;
      poly_end_ff <= poly_end_in;
      hole_ff     <= hole_in;
      open_ff     <= open_in;
      closing_ff  <= closing_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      c_ff        <= c_in;
      prod_ff     <= prod_in;
   end

   a_started_after_open_vertex: assert property (@(posedge clock) disable iff (reset)
      (accept && !in_cont_end) |=> started_ff)
      else $error("Contour not marked as started after a vertex that does not close it.");

   a_vcount_bound: assert property (@(posedge clock) disable iff (reset)
      vcount_ff <= VCOUNT_W'(MAX_VERTICES + 1))
      else $error("Vertex count passed its saturation value.");

endmodule

/* rtl/core/pac_queue.sv */
// Short queue of contour results between the front end and the back end.
module pac_queue import pac_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  pac_entry_type push_data,
   output logic          pop_valid,
   input  logic          pop_ready,
   output pac_entry_type pop_data
);

   pac_entry_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? (wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? (rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/pac_divider.sv */
// Restoring divider that produces one quotient bit per cycle.
module pac_divider import pac_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DVS_W-1:0] dvs,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DCNT_W-1:0] count_ff, count_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial, diff;
   logic              ge;

   assign busy  = (count_ff != '0);
   assign done  = done_ff;
   assign quo   = quo_ff;
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = num;
         rem_in   = '0;
         dvs_in   = dvs;
         count_in = DCNT_W'(NUM_W);
      end else if (busy) begin
         quo_in   = {quo_ff[NUM_W-2:0], ge};
         rem_in   = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         count_in = count_ff - DCNT_W'(1);
         done_in  = (count_ff == DCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   a_done_follows_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy))
      else $error("Divider reported done without a division in progress.");

endmodule

/* rtl/core/pac_back.sv */
// Back end: computes the polygon centroid and holds the response register.
module pac_back import pac_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  pac_entry_type pop_data,
   pac_rsp_if.source     rsp_chan
);

   back_state_type state_ff, state_in;

   pac_entry_type            ent_ff, ent_in;
   logic [AREA_W-1:0]        abs_area_ff, abs_area_in;
   logic [MOM_W-1:0]         abs_mx_ff, abs_mx_in, abs_my_ff, abs_my_in;
   logic                     negx_ff, negx_in, negy_ff, negy_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [NUM_W-1:0]         numy_ff, numy_in;
   logic signed [CENT_W-1:0] cx_ff, cx_in, cy_ff, cy_in;

   logic                     out_valid_ff, out_valid_in;
   logic signed [AREA_W-1:0] out_carea_ff, out_carea_in;
   logic                     out_cw_ff, out_cw_in;
   logic                     out_done_ff, out_done_in;
   logic signed [AREA_W-1:0] out_parea_ff, out_parea_in;
   logic signed [CENT_W-1:0] out_cx_ff, out_cx_in, out_cy_ff, out_cy_in;
   status_type               out_status_ff, out_status_in;

   status_type               head_status;
   logic                     needs_div, out_free, load_direct, load_div;
   logic                     div_start, div_busy, div_done;
   logic [NUM_W-1:0]         numx, div_num, div_quo;
   logic [DVS_W-1:0]         div_dvs;

   function automatic logic signed [CENT_W-1:0] saturate(input logic [NUM_W-1:0] q,
                                                         input logic neg);
      logic [NUM_W-1:0]      lim;
      logic [NUM_W-1:0]      mag;
      logic [COORD_BITS-1:0] r;
      lim = NUM_W'(1) << (COORD_BITS - 1);
      if (neg) begin
         mag = (q > lim) ? lim : q;
      end else begin
         mag = (q > (lim - NUM_W'(1))) ? (lim - NUM_W'(1)) : q;
      end
      r = neg ? COORD_BITS'(NUM_W'(0) - mag) : COORD_BITS'(mag);
      return CENT_W'(signed'(r));
   endfunction

   always_comb begin
      if (pop_data.overflow) begin
         head_status = STATUS_OVERFLOW;
      end else if (pop_data.poly_area == '0) begin
         head_status = STATUS_ZERO_AREA;
      end else begin
         head_status = STATUS_OK;
      end
   end

   assign needs_div = pop_data.done && (head_status == STATUS_OK);
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign numx      = (NUM_W'(abs_mx_ff) << 1) + NUM_W'(den_ff);
   assign div_dvs   = DVS_W'(den_ff) << 1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid && needs_div) begin
               state_in = B_ABS;
            end
         end
         B_ABS: state_in = B_DEN;
         B_DEN: state_in = B_NUM;
         B_NUM: state_in = B_DIVX;
         B_DIVX: begin
            if (div_done) begin
               state_in = B_DIVY;
            end
         end
         B_DIVY: begin
            if (div_done) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop_ready   = (state_ff == B_IDLE) && pop_valid && (needs_div || out_free);
      load_direct = (state_ff == B_IDLE) && pop_valid && !needs_div && out_free;
      load_div    = (state_ff == B_OUT) && out_free;
      div_start   = (state_ff == B_NUM) || ((state_ff == B_DIVX) && div_done);
      div_num     = (state_ff == B_NUM) ? numx : numy_ff;
   end

   always_comb begin
      ent_in      = ent_ff;
      abs_area_in = abs_area_ff;
      abs_mx_in   = abs_mx_ff;
      abs_my_in   = abs_my_ff;
      negx_in     = negx_ff;
      negy_in     = negy_ff;
      den_in      = den_ff;
      numy_in     = numy_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      case (state_ff)
         B_IDLE: begin
            ent_in = pop_data;
         end
         B_ABS: begin
            abs_area_in = ent_ff.poly_area[AREA_W-1] ? (AREA_W'(0) - ent_ff.poly_area)
                                                     : ent_ff.poly_area;
            abs_mx_in   = ent_ff.moment_x[MOM_W-1] ? (MOM_W'(0) - ent_ff.moment_x)
                                                   : ent_ff.moment_x;
            abs_my_in   = ent_ff.moment_y[MOM_W-1] ? (MOM_W'(0) - ent_ff.moment_y)
                                                   : ent_ff.moment_y;
            negx_in     = ent_ff.moment_x[MOM_W-1] ^ ent_ff.poly_area[AREA_W-1];
            negy_in     = ent_ff.moment_y[MOM_W-1] ^ ent_ff.poly_area[AREA_W-1];
         end
         B_DEN: begin
            den_in = DEN_W'(abs_area_ff) + (DEN_W'(abs_area_ff) << 1);
         end
         B_NUM: begin
            numy_in = (NUM_W'(abs_my_ff) << 1) + NUM_W'(den_ff);
         end
         B_DIVX: begin
            if (div_done) begin
               cx_in = saturate(div_quo, negx_ff);
            end
         end
         B_DIVY: begin
            if (div_done) begin
               cy_in = saturate(div_quo, negy_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_carea_in  = out_carea_ff;
      out_cw_in     = out_cw_ff;
      out_done_in   = out_done_ff;
      out_parea_in  = out_parea_ff;
      out_cx_in     = out_cx_ff;
      out_cy_in     = out_cy_ff;
      out_status_in = out_status_ff;
      if (load_direct) begin
         out_valid_in  = 1'b1;
         out_carea_in  = pop_data.contour_area;
         out_cw_in     = pop_data.clockwise;
         out_done_in   = pop_data.done;
         out_parea_in  = pop_data.done ? pop_data.poly_area : '0;
         out_cx_in     = '0;
         out_cy_in     = '0;
         out_status_in = pop_data.done ? head_status : STATUS_OK;
      end else if (load_div) begin
         out_valid_in  = 1'b1;
         out_carea_in  = ent_ff.contour_area;
         out_cw_in     = ent_ff.clockwise;
         out_done_in   = 1'b1;
         out_parea_in  = ent_ff.poly_area;
         out_cx_in     = cx_ff;
         out_cy_in     = cy_ff;
         out_status_in = STATUS_OK;
      end
   end

   pac_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .dvs   (div_dvs),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff        <= ent_in;
      abs_area_ff   <= abs_area_in;
      abs_mx_ff     <= abs_mx_in;
      abs_my_ff     <= abs_my_in;
      negx_ff       <= negx_in;
      negy_ff       <= negy_in;
      den_ff        <= den_in;
      numy_ff       <= numy_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      out_carea_ff  <= out_carea_in;
      out_cw_ff     <= out_cw_in;
      out_done_ff   <= out_done_in;
      out_parea_ff  <= out_parea_in;
      out_cx_ff     <= out_cx_in;
      out_cy_ff     <= out_cy_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_chan.valid               = out_valid_ff;
   assign rsp_chan.contour_double_area = out_carea_ff;
   assign rsp_chan.contour_clockwise   = out_cw_ff;
   assign rsp_chan.polygon_done        = out_done_ff;
   assign rsp_chan.polygon_double_area = out_parea_ff;
   assign rsp_chan.centroid_x          = out_cx_ff;
   assign rsp_chan.centroid_y          = out_cy_ff;
   assign rsp_chan.status              = out_status_ff;

   a_div_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("Divider started while a division was in progress.");

   a_no_centroid_without_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (!out_done_ff || (out_status_ff != STATUS_OK)))
      |-> ((out_cx_ff == '0) && (out_cy_ff == '0)))
      else $error("Centroid is nonzero on a response that carries no centroid.");

endmodule

/* rtl/core/polygon_area_centroid.sv */
// Polygon area and centroid top level. Vertices arrive one request at a time;
// each contour end produces one response with twice the contour's signed area
// and its winding, and a polygon end also carries twice the net area (outer
// contours added, holes subtracted, open contours ignored), the centroid and a
// status code. The first vertex of a contour is only stored, unless it also
// closes the contour; any later vertex that does not close the contour runs
// through the front end's edge steps (two-stage cross product, one shared
// moment multiplier used twice, accumulate). A closing vertex runs its own
// edge and then the closing edge through the same edge datapath, or just the
// closing edge when it is the only vertex of its contour; it takes longer while
// the result queue is full. Polygon ends with a valid area are finished in the
// back end by a one-bit-per-cycle restoring divider used for x and then y; a
// two-entry result queue lets the front end keep taking vertices meanwhile, and
// a response register holds a result until it is taken.
module polygon_area_centroid import pac_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pac_req_if.sink   req_chan,
   pac_rsp_if.source rsp_chan
);

   logic          push_valid, push_ready, pop_valid, pop_ready;
   pac_entry_type push_data, pop_data;

   pac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   pac_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule
